// ===== hw/rtl/bf3_pkg.sv =====
// Shared types and constants of the 3x3 box-mean filter.
`default_nettype none

package bf3_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Frame geometry limits
   localparam int MIN_SIZE   = 3;
   localparam int MAX_HEIGHT = 256;
   localparam int ROW_W      = 9;

   // Window arithmetic: floor(s / 9) as (s * 7282) >> 16, exact for s below 32768
   localparam int PIX_W      = 8;
   localparam int ROWSUM_W   = 10;
   localparam int SUM_W      = 12;
   localparam int RECIP_W    = 13;
   localparam int PROD_W     = SUM_W + RECIP_W;
   localparam int MEAN_SHIFT = 16;
   localparam logic [RECIP_W-1:0] MEAN_RECIP = 13'd7282;

   // Tick queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic             kind;
      logic [PIX_W-1:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] mean_value;
      logic             frame_last;
   } rsp_type;

   // One classified tick: what the back end has to do with it.
   // Mask bit j selects window row j (0 is the top) or column j (0 is the left).
   typedef struct packed {
      logic             shift;
      logic             emit;
      logic             last;
      logic [2:0]       row_mask;
      logic [2:0]       col_mask;
      logic [PIX_W-1:0] pixel;
   } tick_ctl_type;

   typedef struct packed {
      logic              full;
      logic              not_empty;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
   } back_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bf3_front.sv =====
// Front end: frame position tracking, configuration registers and tick classification.
`default_nettype none

module bf3_front #(
   parameter int MAX_WIDTH = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire bf3_pkg::req_type                   req_data,
   input  wire logic                               csr_write_enable,
   input  wire logic [bf3_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bf3_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output bf3_pkg::tick_ctl_type                   tick_ctl,
   output logic [$clog2(MAX_WIDTH)-1:0]            tick_addr
);
   import bf3_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int AW = $clog2(MAX_WIDTH);

   logic [CW-1:0]    width_ff;
   logic [ROW_W-1:0] height_ff;
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [CW-1:0]    col_now, col_inc;
   logic [ROW_W-1:0] row_now, height_plus1;
   logic [CW-1:0]    width_clamped;
   logic [ROW_W-1:0] height_clamped;

   assign height_plus1 = height_ff + ROW_W'(1);

   always_comb begin
      if (csr_write_data < CSR_DATA_W'(MIN_SIZE)) begin
         width_clamped = CW'(MIN_SIZE);
      end else if (32'(csr_write_data) > 32'(MAX_WIDTH)) begin
         width_clamped = CW'(MAX_WIDTH);
      end else begin
         width_clamped = CW'(csr_write_data);
      end
      if (csr_write_data < CSR_DATA_W'(MIN_SIZE)) begin
         height_clamped = ROW_W'(MIN_SIZE);
      end else if (32'(csr_write_data) > 32'(MAX_HEIGHT)) begin
         height_clamped = ROW_W'(MAX_HEIGHT);
      end else begin
         height_clamped = ROW_W'(csr_write_data);
      end
   end

   always_comb begin
      row_now = row_ff;
      col_now = col_ff;
      if (row_now > height_plus1 || col_now >= width_ff) begin
         row_now = '0;
         col_now = '0;
      end
      col_inc = col_now + CW'(1);

      tick_ctl.pixel = (req_data.kind || row_now >= height_ff) ? '0 : req_data.pixel_value;
      tick_ctl.shift = 1'b1;
      tick_ctl.last  = 1'b0;
      if (col_now == '0) begin
         // Column zero finishes the previous row's last pixel before shifting.
         tick_ctl.emit     = row_now >= ROW_W'(2);
         tick_ctl.last     = row_now == height_plus1;
         tick_ctl.shift    = !(row_now == height_plus1);
         tick_ctl.row_mask = (row_now == ROW_W'(2)) ? 3'b110 : 3'b111;
         // After the shift the old middle and right columns sit on the left.
         tick_ctl.col_mask = (row_now == height_plus1) ? 3'b110 : 3'b011;
      end else begin
         tick_ctl.emit     = row_now >= ROW_W'(1);
         tick_ctl.row_mask = (row_now == ROW_W'(1)) ? 3'b110 : 3'b111;
         tick_ctl.col_mask = (col_now == CW'(1)) ? 3'b110 : 3'b111;
      end

      if (tick_ctl.last) begin
         row_in = '0;
         col_in = '0;
      end else if (col_inc >= width_ff) begin
         row_in = row_now + ROW_W'(1);
         col_in = '0;
      end else begin
         row_in = row_now;
         col_in = col_inc;
      end
   end

   assign tick_addr = col_now[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= (MAX_WIDTH < MAX_HEIGHT) ? CW'(MAX_WIDTH) : CW'(MAX_HEIGHT);
         height_ff <= ROW_W'(MAX_HEIGHT);
         row_ff    <= '0;
         col_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LINE_WIDTH: begin
               width_ff <= width_clamped;
            end
            CSR_FRAME_HEIGHT: begin
               height_ff <= height_clamped;
            end
            default: begin
               width_ff <= width_ff;
            end
         endcase
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bf3_queue.sv =====
// Two-entry tick queue between the front and back ends.
`default_nettype none

module bf3_queue #(
   parameter int DATA_W = 24
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [DATA_W-1:0]          push_data,
   input  wire logic                       pop,
   output logic [DATA_W-1:0]               pop_data,
   output bf3_pkg::queue_status_type       status
);
   import bf3_pkg::*;

   logic [DATA_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign count_in         = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   assign status.count     = count_ff;
   assign status.full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign status.not_empty = count_ff != '0;
   assign pop_data         = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bf3_back.sv =====
// Back end: line stores, 3x3 window, masked window sum and divide-by-nine output stage.
`default_nettype none

module bf3_back #(
   parameter int MAX_WIDTH = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           tick_valid,
   input  wire bf3_pkg::tick_ctl_type          tick_ctl,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]   tick_addr,
   output logic                                tick_pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output bf3_pkg::rsp_type                    rsp_data,
   output bf3_pkg::back_status_type            status
);
   import bf3_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

   // Stage 1: tick plus the two line-store words read for its column
   logic             s1_valid_ff;
   tick_ctl_type     s1_ctl_ff;
   logic [AW-1:0]    s1_addr_ff;
   logic [PIX_W-1:0] upper_rd_ff, middle_rd_ff;

   // Stage 2: window sum of a tick that gives a result
   logic             s2_valid_ff;
   logic [SUM_W-1:0] s2_sum_ff;
   logic             s2_last_ff;

   // Output register
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic [PIX_W-1:0]    win_ff   [3][3];
   logic [PIX_W-1:0]    win_next [3][3];
   logic [ROWSUM_W-1:0] row_sum  [3];
   logic [SUM_W-1:0]    sum;
   logic [PROD_W-1:0]   product;

   logic out_free, s2_take, s1_take, s1_adv;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s2_take  = !s2_valid_ff || out_free;
   assign s1_take  = !s1_valid_ff || s2_take;
   assign s1_adv   = s1_valid_ff && s2_take;
   assign tick_pop = tick_valid && s1_take;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            win_next[i][j] = win_ff[i][j];
         end
      end
      if (s1_ctl_ff.shift) begin
         for (int i = 0; i < 3; i++) begin
            win_next[i][0] = win_ff[i][1];
            win_next[i][1] = win_ff[i][2];
         end
         win_next[0][2] = upper_rd_ff;
         win_next[1][2] = middle_rd_ff;
         win_next[2][2] = s1_ctl_ff.pixel;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         row_sum[i] = '0;
         if (s1_ctl_ff.row_mask[i]) begin
            row_sum[i] = (s1_ctl_ff.col_mask[0] ? ROWSUM_W'(win_next[i][0]) : '0)
                       + (s1_ctl_ff.col_mask[1] ? ROWSUM_W'(win_next[i][1]) : '0)
                       + (s1_ctl_ff.col_mask[2] ? ROWSUM_W'(win_next[i][2]) : '0);
         end
      end
      sum = SUM_W'(row_sum[0]) + SUM_W'(row_sum[1]) + SUM_W'(row_sum[2]);
   end

   assign product = PROD_W'(s2_sum_ff) * PROD_W'(MEAN_RECIP);

   always_ff @(posedge clock) begin
      if (tick_pop) begin
         upper_rd_ff <= upper_mem[tick_addr];
      end
      if (s1_adv && s1_ctl_ff.shift) begin
         upper_mem[s1_addr_ff] <= middle_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_pop) begin
         middle_rd_ff <= middle_mem[tick_addr];
      end
      if (s1_adv && s1_ctl_ff.shift) begin
         middle_mem[s1_addr_ff] <= s1_ctl_ff.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_take) begin
            s1_valid_ff <= tick_valid;
         end
         if (s2_take) begin
            s2_valid_ff <= s1_valid_ff && s1_ctl_ff.emit;
         end
         if (out_free) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick_pop) begin
         s1_ctl_ff  <= tick_ctl;
         s1_addr_ff <= tick_addr;
      end
      if (s1_adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= win_next[i][j];
            end
         end
      end
      if (s2_take) begin
         s2_sum_ff  <= sum;
         s2_last_ff <= s1_ctl_ff.last;
      end
      if (out_free) begin
         rsp_data_ff.mean_value <= product[MEAN_SHIFT +: PIX_W];
         rsp_data_ff.frame_last <= s2_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign status.s1_valid = s1_valid_ff;
   assign status.s2_valid = s2_valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/box_filter_3x3_gray.sv =====
// Top level of the 3x3 box-mean filter for a raster stream of 8-bit grey pixels.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_ready   req_data: kind, pixel_value
//   rsp_      out        rsp_valid / rsp_ready   rsp_data: mean_value, frame_last
//   csr_      in         csr_write_enable        csr_index, csr_write_data
//
// The block takes one pixel transfer per clock while the queue has room (req_ready high)
// and gives at most one result per clock. A tick passes the front end, the two-entry
// queue, the line-store read stage, the window/sum stage and the output register.
// Reset needs no clearing pass: every line-store entry that feeds a result has been
// written earlier in the same frame, so the stores start with whatever they hold.
// A stall on rsp_ready holds the back end; the queue keeps req_ready high for a while.
`default_nettype none

module box_filter_3x3_gray #(
   parameter int MAX_WIDTH = 256
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire bf3_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output bf3_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_write_enable,
   input  wire logic [bf3_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bf3_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import bf3_pkg::*;

   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int CTL_W  = $bits(tick_ctl_type);
   localparam int DATA_W = AW + CTL_W;

   tick_ctl_type      front_ctl, back_ctl;
   logic [AW-1:0]     front_addr, back_addr;
   logic [DATA_W-1:0] q_push_data, q_pop_data;
   logic              q_push, q_pop;
   queue_status_type  q_status;
   back_status_type   back_status;

   // The front end only takes a pixel when the queue has room for its tick.
   assign req_ready = !q_status.full;
   assign q_push    = req_valid && req_ready;

   bf3_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (q_push),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .tick_ctl         (front_ctl),
      .tick_addr        (front_addr)
   );

   assign q_push_data = {front_addr, front_ctl};

   bf3_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   assign back_addr = q_pop_data[DATA_W-1:CTL_W];
   assign back_ctl  = tick_ctl_type'(q_pop_data[CTL_W-1:0]);

   bf3_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .tick_valid (q_status.not_empty),
      .tick_ctl   (back_ctl),
      .tick_addr  (back_addr),
      .tick_pop   (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .status     (back_status)
   );

   // The back end never takes a tick from an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_status.not_empty)
      else $error("tick taken from an empty queue");

   // A tick taken from the queue sits in the line-store read stage on the next cycle.
   assert property (@(posedge clock) disable iff (reset) q_pop |=> back_status.s1_valid)
      else $error("tick lost between the queue and the read stage");

   // Queue occupancy follows the pushes and pops of the previous cycle.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (q_status.count == $past(q_status.count)
                         + QCNT_W'($past(q_push)) - QCNT_W'($past(q_pop))))
      else $error("queue occupancy lost track of transfers");

   // A new result only appears when the sum stage held a result-giving tick.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(back_status.s2_valid))
      else $error("result raised without a window sum behind it");

   // A pending sum is not lost while the output register is stalled.
   assert property (@(posedge clock) disable iff (reset)
      (back_status.s2_valid && rsp_valid && !rsp_ready) |=> back_status.s2_valid)
      else $error("window sum dropped during an output stall");

endmodule

`default_nettype wire
